>>> design/gt_pkg.sv
// shared types and constants of the graph traversal engine
`timescale 1ns / 1ps
`default_nettype none
package gt_pkg;

  localparam int NB   = 6;
  localparam int SB   = 3;
  localparam int FB   = 2;
  localparam int CNTW = 7;
  localparam int CIW  = 8;

  localparam logic [FB-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FB-1:0] FUNC_START = 2'd1;
  localparam logic [FB-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [SB-1:0] ST_VISIT   = 3'd0;
  localparam logic [SB-1:0] ST_ADDED   = 3'd1;
  localparam logic [SB-1:0] ST_FULL    = 3'd2;
  localparam logic [SB-1:0] ST_BAD     = 3'd3;
  localparam logic [SB-1:0] ST_CLEARED = 3'd4;

  localparam logic [CIW-1:0] REG_NODE_COUNT = 8'd0;
  localparam logic [CIW-1:0] REG_ORDER      = 8'd1;

  typedef struct packed {
    logic [NB-1:0] node;
    logic [SB-1:0] status;
    logic          last;
  } gt_res_t;

endpackage
`default_nettype wire

>>> design/gt_ram.sv
// single-port-write synchronous-read memory
`timescale 1ns / 1ps
`default_nettype none
module gt_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> design/gt_list_store.sv
// per-node list head and tail memory with valid bits
`timescale 1ns / 1ps
`default_nettype none
module gt_list_store #(
  parameter int NODES = 64,
  parameter int AW    = 6,
  parameter int EW    = 9,
  parameter int EDGES = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clr_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [EW-1:0] whead_i,
  input  wire logic [EW-1:0] wtail_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [EW-1:0] rhead_o,
  output logic      [EW-1:0] rtail_o
);

  localparam logic [EW-1:0] Nil = EW'(EDGES);

  logic [2*EW-1:0]  mem [NODES];
  logic [2*EW-1:0]  rd_q;
  logic [NODES-1:0] vld_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {whead_i, wtail_i};
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[raddr_i];
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rhead_o = rvld_q ? rd_q[2*EW-1:EW] : Nil;
  assign rtail_o = rvld_q ? rd_q[EW-1:0]    : Nil;

endmodule
`default_nettype wire

>>> design/gt_out_stage.sv
// result holding slot and output register, marks the final word of a run
`timescale 1ns / 1ps
`default_nettype none
module gt_out_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire logic            fin_i,
  input  wire gt_pkg::gt_res_t res_i,
  output logic                 rdy_o,
  input  wire logic            out_stall_i,
  output logic                 out_valid_o,
  output gt_pkg::gt_res_t      res_o
);
  import gt_pkg::*;

  logic    pend_v_q;
  logic    out_v_q;
  gt_res_t pend_q;
  gt_res_t out_q;
  logic    out_free;
  logic    move;

  assign out_free = !out_v_q || !out_stall_i;
  assign move     = pend_v_q && out_free && (pend_q.last || push_i || fin_i);
  assign rdy_o    = !pend_v_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (move) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (push_i && rdy_o) begin
        pend_v_q <= 1'b1;
      end else if (move) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= '{node: pend_q.node, status: pend_q.status, last: pend_q.last | fin_i};
    end
    if (push_i && rdy_o) begin
      pend_q <= res_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule
`default_nettype wire

>>> design/graph_traversal_bfs_dfs.sv
// top level: graph store and breadth-first or depth-first traversal sequencer
// add edge and clear: one result after acceptance; no new item is taken until that result
// has been handed to the output stage
// start: checks each root in turn and walks from it, through the registered reads of the
// edge and list memories, for each node reached and each edge walked
// the last visit is marked final as the walk ends; the next item is taken after it leaves
// reset: node count 8, breadth-first, no edges, ready at once with no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module graph_traversal_bfs_dfs #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [gt_pkg::CIW-1:0]  cfg_index_i,
  input  wire logic [gt_pkg::CNTW-1:0] cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [gt_pkg::FB-1:0] func_i,
  input  wire logic [gt_pkg::NB-1:0] src_node_i,
  input  wire logic [gt_pkg::NB-1:0] dst_node_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [gt_pkg::NB-1:0]     visited_node_o,
  output logic [gt_pkg::SB-1:0]     status_o,
  output logic                      last_o
);
  import gt_pkg::*;

  localparam int NAW = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam logic [EW-1:0]   Nil  = EW'(MAX_EDGES);
  localparam logic [CNTW-1:0] NMax = CNTW'(MAX_NODES);
  localparam logic [CW-1:0]   CMax = CW'(MAX_NODES);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_LINK, S_ACK, S_ROOT, S_BRD, S_BV, S_BHD, S_BE, S_BT,
    S_DHD, S_DE, S_DPOP, S_DT, S_FIN
  } state_e;

  state_e          state_q;
  logic [CNTW-1:0] node_count_q;
  logic            order_q;
  logic [EW-1:0]   used_q;
  logic [NB-1:0]   s_q;
  logic [NB-1:0]   d_q;
  logic [SB-1:0]   status_q;
  logic [CW-1:0]   root_q;
  logic [CW-1:0]   qh_q;
  logic [CW-1:0]   qt_q;
  logic [CW-1:0]   sp_q;
  logic [EW-1:0]   cur_q;
  logic [EW-1:0]   tail_q;
  logic [MAX_NODES-1:0] visited_q;

  logic [CNTW-1:0] n_eff;
  logic            accept;
  logic [NB-1:0]   tgt_rd;
  logic [EW-1:0]   lnk_rd;
  logic [EW-1:0]   head_rd;
  logic [EW-1:0]   tail_rd;
  logic [NAW-1:0]  wn_rd;
  logic [EW-1:0]   cc_rd;
  logic            t_ok;
  logic [CW-1:0]   sp_m1;
  logic [CW-1:0]   sp_m2;

  logic            tgt_we;
  logic            lnk_we;
  logic [EAW-1:0]  lnk_waddr;
  logic [EW-1:0]   lnk_wdata;
  logic            ls_we;
  logic            ls_clr;
  logic [EW-1:0]   ls_whead;
  logic [NAW-1:0]  ls_raddr;
  logic            wn_we;
  logic [NAW-1:0]  wn_waddr;
  logic [NAW-1:0]  wn_wdata;
  logic            cc_we;

  logic            push;
  logic            fin;
  logic            rdy;
  gt_res_t         res;
  gt_res_t         out_res;

  assign n_eff  = (node_count_q > NMax) ? NMax : node_count_q;
  assign accept = in_valid_i && (state_q == S_IDLE);
  assign t_ok   = (CNTW'(tgt_rd) < n_eff) && !visited_q[tgt_rd[NAW-1:0]];
  assign sp_m1  = sp_q - CW'(1);
  assign sp_m2  = sp_q - CW'(2);

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  always_comb begin
    tgt_we    = 1'b0;
    lnk_we    = 1'b0;
    lnk_waddr = used_q[EAW-1:0];
    lnk_wdata = Nil;
    ls_we     = 1'b0;
    ls_clr    = 1'b0;
    ls_whead  = (head_rd == Nil) ? used_q : head_rd;
    ls_raddr  = src_node_i[NAW-1:0];
    wn_we     = 1'b0;
    wn_waddr  = qt_q[NAW-1:0];
    wn_wdata  = tgt_rd[NAW-1:0];
    cc_we     = 1'b0;
    push      = 1'b0;
    fin       = 1'b0;
    res       = '{node: '0, status: ST_VISIT, last: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        ls_clr = accept && (func_i == FUNC_CLEAR);
      end
      S_ADD: begin
        tgt_we = 1'b1;
        lnk_we = 1'b1;
        ls_we  = 1'b1;
      end
      S_LINK: begin
        lnk_we    = 1'b1;
        lnk_waddr = tail_q[EAW-1:0];
        lnk_wdata = used_q;
      end
      S_ACK: begin
        push = 1'b1;
        res  = '{node: '0, status: status_q, last: 1'b1};
      end
      S_ROOT: begin
        ls_raddr = root_q[NAW-1:0];
        if ((CNTW'(root_q) != n_eff) && !visited_q[root_q[NAW-1:0]]) begin
          if (!order_q) begin
            wn_we    = 1'b1;
            wn_waddr = '0;
            wn_wdata = root_q[NAW-1:0];
          end else begin
            push = 1'b1;
            res  = '{node: NB'(root_q), status: ST_VISIT, last: 1'b0};
          end
        end
      end
      S_BV: begin
        ls_raddr = wn_rd;
        push     = 1'b1;
        res      = '{node: NB'(wn_rd), status: ST_VISIT, last: 1'b0};
      end
      S_BT: begin
        wn_we = t_ok && (qt_q < CMax);
      end
      S_DT: begin
        ls_raddr = tgt_rd[NAW-1:0];
        if (t_ok && (sp_q < CMax)) begin
          push  = 1'b1;
          cc_we = rdy;
          res   = '{node: tgt_rd, status: ST_VISIT, last: 1'b0};
        end
      end
      S_FIN: begin
        fin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= CNTW'(8);
      order_q      <= 1'b0;
      used_q       <= '0;
      s_q          <= '0;
      d_q          <= '0;
      status_q     <= ST_VISIT;
      root_q       <= '0;
      qh_q         <= '0;
      qt_q         <= '0;
      sp_q         <= '0;
      cur_q        <= Nil;
      tail_q       <= Nil;
      visited_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_NODE_COUNT) begin
          node_count_q <= cfg_data_i;
        end else if (cfg_index_i == REG_ORDER) begin
          order_q <= cfg_data_i[0];
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            s_q <= src_node_i;
            d_q <= dst_node_i;
            unique case (func_i)
              FUNC_ADD: begin
                if ((CNTW'(src_node_i) >= n_eff) || (CNTW'(dst_node_i) >= n_eff)) begin
                  status_q <= ST_BAD;
                  state_q  <= S_ACK;
                end else if (used_q == Nil) begin
                  status_q <= ST_FULL;
                  state_q  <= S_ACK;
                end else begin
                  state_q <= S_ADD;
                end
              end
              FUNC_CLEAR: begin
                used_q   <= '0;
                status_q <= ST_CLEARED;
                state_q  <= S_ACK;
              end
              FUNC_START: begin
                visited_q <= '0;
                root_q    <= '0;
                state_q   <= S_ROOT;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD: begin
          if (tail_rd == Nil) begin
            used_q   <= used_q + EW'(1);
            status_q <= ST_ADDED;
            state_q  <= S_ACK;
          end else begin
            tail_q  <= tail_rd;
            state_q <= S_LINK;
          end
        end
        S_LINK: begin
          used_q   <= used_q + EW'(1);
          status_q <= ST_ADDED;
          state_q  <= S_ACK;
        end
        S_ACK: begin
          if (rdy) begin
            state_q <= S_IDLE;
          end
        end
        S_ROOT: begin
          if (CNTW'(root_q) == n_eff) begin
            state_q <= S_FIN;
          end else if (visited_q[root_q[NAW-1:0]]) begin
            root_q <= root_q + CW'(1);
          end else if (!order_q) begin
            visited_q[root_q[NAW-1:0]] <= 1'b1;
            qh_q    <= '0;
            qt_q    <= CW'(1);
            state_q <= S_BRD;
          end else if (rdy) begin
            visited_q[root_q[NAW-1:0]] <= 1'b1;
            sp_q    <= CW'(1);
            state_q <= S_DHD;
          end
        end
        S_BRD: begin
          if (qh_q == qt_q) begin
            root_q  <= root_q + CW'(1);
            state_q <= S_ROOT;
          end else begin
            state_q <= S_BV;
          end
        end
        S_BV: begin
          if (rdy) begin
            qh_q    <= qh_q + CW'(1);
            state_q <= S_BHD;
          end
        end
        S_BHD: begin
          cur_q   <= head_rd;
          state_q <= S_BE;
        end
        S_BE: begin
          state_q <= (cur_q == Nil) ? S_BRD : S_BT;
        end
        S_BT: begin
          if (t_ok && (qt_q < CMax)) begin
            visited_q[tgt_rd[NAW-1:0]] <= 1'b1;
            qt_q <= qt_q + CW'(1);
          end
          cur_q   <= lnk_rd;
          state_q <= S_BE;
        end
        S_DHD: begin
          cur_q   <= head_rd;
          state_q <= S_DE;
        end
        S_DE: begin
          if (cur_q == Nil) begin
            if (sp_q == CW'(1)) begin
              sp_q    <= '0;
              root_q  <= root_q + CW'(1);
              state_q <= S_ROOT;
            end else begin
              sp_q    <= sp_m1;
              state_q <= S_DPOP;
            end
          end else begin
            state_q <= S_DT;
          end
        end
        S_DPOP: begin
          cur_q   <= cc_rd;
          state_q <= S_DE;
        end
        S_DT: begin
          if (t_ok && (sp_q < CMax)) begin
            if (rdy) begin
              visited_q[tgt_rd[NAW-1:0]] <= 1'b1;
              sp_q    <= sp_q + CW'(1);
              state_q <= S_DHD;
            end
          end else begin
            cur_q   <= lnk_rd;
            state_q <= S_DE;
          end
        end
        S_FIN: begin
          if (rdy) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  gt_ram #(.W(NB), .D(MAX_EDGES), .AW(EAW)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (tgt_we),
    .waddr_i (used_q[EAW-1:0]),
    .wdata_i (d_q),
    .raddr_i (cur_q[EAW-1:0]),
    .rdata_o (tgt_rd)
  );

  gt_ram #(.W(EW), .D(MAX_EDGES), .AW(EAW)) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .raddr_i (cur_q[EAW-1:0]),
    .rdata_o (lnk_rd)
  );

  gt_list_store #(.NODES(MAX_NODES), .AW(NAW), .EW(EW), .EDGES(MAX_EDGES)) u_list (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (ls_clr),
    .we_i    (ls_we),
    .waddr_i (s_q[NAW-1:0]),
    .whead_i (ls_whead),
    .wtail_i (used_q),
    .raddr_i (ls_raddr),
    .rhead_o (head_rd),
    .rtail_o (tail_rd)
  );

  gt_ram #(.W(NAW), .D(MAX_NODES), .AW(NAW)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (wn_we),
    .waddr_i (wn_waddr),
    .wdata_i (wn_wdata),
    .raddr_i (qh_q[NAW-1:0]),
    .rdata_o (wn_rd)
  );

  gt_ram #(.W(EW), .D(MAX_NODES), .AW(NAW)) u_cursor_ram (
    .clk_i   (clk_i),
    .we_i    (cc_we),
    .waddr_i (sp_m1[NAW-1:0]),
    .wdata_i (lnk_rd),
    .raddr_i (sp_m2[NAW-1:0]),
    .rdata_o (cc_rd)
  );

  gt_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .fin_i       (fin),
    .res_i       (res),
    .rdy_o       (rdy),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign visited_node_o = out_res.node;
  assign status_o       = out_res.status;
  assign last_o         = out_res.last;

endmodule
`default_nettype wire

>>> dv/graph_traversal_bfs_dfs_test.sv
// testbench for the graph traversal engine: directed and random edge loads and walks
`timescale 1ns / 1ps
module graph_traversal_bfs_dfs_test;
  import gt_pkg::*;

  localparam int MAXN = 64;
  localparam int MAXE = 256;
  localparam int NILE = MAXE;

  class walk_scoreboard;
    int unsigned tgt[MAXE];
    int unsigned nxt[MAXE];
    int unsigned head[MAXN];
    int unsigned tail[MAXN];
    int unsigned used;
    bit mark[MAXN];
    int unsigned ncount;
    bit dfs;
    gt_res_t pending[$];
    int errors;

    function void init();
      for (int i = 0; i < MAXN; i++) begin
        head[i] = NILE;
        tail[i] = NILE;
      end
      used = 0;
      ncount = 8;
      dfs = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CIW-1:0] idx, logic [CNTW-1:0] val);
      if (idx == REG_NODE_COUNT) ncount = val;
      else if (idx == REG_ORDER) dfs = val[0];
    endfunction

    function void push(int unsigned node, logic [SB-1:0] st);
      gt_res_t r;
      r.node = node[NB-1:0];
      r.status = st;
      r.last = 0;
      pending.insert(pending.size(), r);
    endfunction

    function void note_input(logic [FB-1:0] f, logic [NB-1:0] s, logic [NB-1:0] d);
      int unsigned n, base, qh, qt, sp, e, t;
      int unsigned wq[MAXN];
      int unsigned cur[MAXN];
      n = ncount > MAXN ? MAXN : ncount;
      base = pending.size();
      if (f == FUNC_ADD) begin
        if (s >= n || d >= n) push(0, ST_BAD);
        else if (used >= MAXE) push(0, ST_FULL);
        else begin
          tgt[used] = d;
          nxt[used] = NILE;
          if (tail[s] < NILE) nxt[tail[s]] = used;
          else head[s] = used;
          tail[s] = used;
          used++;
          push(0, ST_ADDED);
        end
      end else if (f == FUNC_CLEAR) begin
        for (int i = 0; i < MAXN; i++) begin
          head[i] = NILE;
          tail[i] = NILE;
        end
        used = 0;
        push(0, ST_CLEARED);
      end else if (f == FUNC_START) begin
        for (int i = 0; i < MAXN; i++) mark[i] = 0;
        for (int root = 0; root < n; root++) begin
          if (mark[root]) continue;
          mark[root] = 1;
          if (!dfs) begin
            qh = 0;
            qt = 1;
            wq[0] = root;
            while (qh < qt) begin
              push(wq[qh], ST_VISIT);
              e = head[wq[qh]];
              qh++;
              while (e < NILE) begin
                t = tgt[e];
                if (t < n && !mark[t] && qt < MAXN) begin
                  mark[t] = 1;
                  wq[qt++] = t;
                end
                e = nxt[e];
              end
            end
          end else begin
            push(root, ST_VISIT);
            cur[0] = head[root];
            sp = 1;
            while (sp > 0) begin
              e = cur[sp-1];
              if (e >= NILE) begin
                sp--;
                continue;
              end
              t = tgt[e];
              cur[sp-1] = nxt[e];
              if (t < n && !mark[t] && sp < MAXN) begin
                mark[t] = 1;
                push(t, ST_VISIT);
                cur[sp] = head[t];
                sp++;
              end
            end
          end
        end
      end
      if (pending.size() > base) pending[pending.size()-1].last = 1;
    endfunction

    function void check_word(gt_res_t act);
      gt_res_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word node=%0d status=%0d last=%0d",
                                   act.node, act.status, act.last);
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r !== act) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp node=%0d status=%0d last=%0d, got node=%0d status=%0d last=%0d",
                   exp_r.node, exp_r.status, exp_r.last, act.node, act.status, act.last);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid_i = 0;
  logic [CIW-1:0] cfg_index_i = '0;
  logic [CNTW-1:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic [FB-1:0] func_i = '0;
  logic [NB-1:0] src_node_i = '0;
  logic [NB-1:0] dst_node_i = '0;
  logic out_stall_i = 0;
  logic cfg_ready_o, in_stall_o, out_valid_o, last_o;
  logic [NB-1:0] visited_node_o;
  logic [SB-1:0] status_o;

  walk_scoreboard sb;
  int burst_left;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  graph_traversal_bfs_dfs DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .func_i, .src_node_i, .dst_node_i,
    .out_valid_o, .out_stall_i, .visited_node_o, .status_o, .last_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word('{node: visited_node_o, status: status_o, last: last_o});
  end

  // receiver stall pattern: calm stretches and busy stretches
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk_i);
      phase = (phase + 1) % 200;
      if (phase < 60) out_stall_i <= 0;
      else out_stall_i <= ($urandom_range(0, 99) < (phase < 130 ? 30 : 70));
    end
  end

  task automatic send_word(logic [FB-1:0] f, logic [NB-1:0] s, logic [NB-1:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i <= 1;
    func_i <= f;
    src_node_i <= s;
    dst_node_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(f, s, d);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CIW-1:0] idx, logic [CNTW-1:0] val);
    drain();
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic load_graph(int unsigned n, int unsigned edges);
    for (int i = 0; i < edges; i++)
      send_word(FUNC_ADD, NB'($urandom_range(0, n - 1)), NB'($urandom_range(0, n - 1)));
  endtask

  initial begin
    int unsigned n;
    sb = new();
    sb.init();
    burst_left = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: defaults, bad nodes, unused code, both orders
    send_word(FUNC_START, 0, 0);
    send_word(FUNC_ADD, 0, 1);
    send_word(FUNC_ADD, 0, 2);
    send_word(FUNC_ADD, 1, 3);
    send_word(FUNC_ADD, 2, 0);
    send_word(FUNC_ADD, 7, 5);
    send_word(FUNC_ADD, 8, 0);
    send_word(FUNC_ADD, 0, 63);
    send_word(2'd3, 63, 63);
    send_word(FUNC_START, 0, 0);
    write_reg(REG_ORDER, 1);
    send_word(FUNC_START, 0, 0);
    write_reg(REG_NODE_COUNT, 3);
    send_word(FUNC_START, 0, 0);
    write_reg(REG_NODE_COUNT, 0);
    send_word(FUNC_ADD, 0, 0);
    send_word(FUNC_START, 0, 0);
    write_reg(REG_NODE_COUNT, 127);
    send_word(FUNC_ADD, 63, 62);
    send_word(FUNC_ADD, 62, 63);
    send_word(FUNC_START, 0, 0);
    write_reg(8'd5, 9);
    send_word(FUNC_CLEAR, 0, 0);
    // a wide sparse graph over all nodes
    load_graph(64, 20);
    send_word(FUNC_START, 0, 0);
    write_reg(REG_ORDER, 0);
    send_word(FUNC_START, 0, 0);
    drain();

    // random phases: clear, load a graph, walk it, some noise
    for (int ph = 0; ph < 5; ph++) begin
      n = (ph == 3) ? $urandom_range(40, 64) : $urandom_range(1, 12);
      write_reg(REG_NODE_COUNT, CNTW'(n));
      write_reg(REG_ORDER, CNTW'($urandom_range(0, 1)));
      send_word(FUNC_CLEAR, NB'($urandom), NB'($urandom));
      load_graph(n, (ph == 3) ? $urandom_range(0, 16) : $urandom_range(0, 2 * n));
      send_word(FUNC_START, NB'($urandom), NB'($urandom));
      send_word(FB'($urandom_range(0, 3)), NB'($urandom), NB'($urandom));
      if (n > 2) begin
        write_reg(REG_NODE_COUNT, CNTW'(n - 1));
        send_word(FUNC_START, NB'($urandom), NB'($urandom));
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> files.f
design/gt_pkg.sv
design/gt_ram.sv
design/gt_list_store.sv
design/gt_out_stage.sv
design/graph_traversal_bfs_dfs.sv
dv/graph_traversal_bfs_dfs_test.sv
